// File: hdl/pas_pkg.sv
// Package for the prefix aggregation stack: sizes, codes, entry type and mask helper.
`default_nettype none

package pas_pkg;

  localparam int DEPTH      = 1024;
  localparam int PTR_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int GROUP_BITS = 16;

  localparam int ADDR_W  = 64;
  localparam int LEN_W   = 8;
  localparam int GRP_W   = 16;
  localparam int IDX_W   = 10;
  localparam int MODE_W  = 2;
  localparam int PFX_W   = 2 * ADDR_W;

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(PFX_W);
  localparam logic [GRP_W-1:0] GROUP_MASK = GRP_W'((33'h1 << GROUP_BITS) - 33'h1);

  localparam logic [MODE_W-1:0] MODE_APPEND = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

  typedef struct packed {
    logic [ADDR_W-1:0] hi;
    logic [ADDR_W-1:0] lo;
    logic [LEN_W-1:0]  len;
    logic [GRP_W-1:0]  grp;
  } entry_t;

  // Mask that keeps the leading n bits of a 128-bit address.
  function automatic logic [PFX_W-1:0] lead_mask(input logic [LEN_W-1:0] n);
    logic [PFX_W-1:0] m;
    if (n >= MAX_LEN) begin
      m = {PFX_W{1'b1}};
    end else begin
      m = ~({PFX_W{1'b1}} >> n);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// File: hdl/pas_if.sv
// Handshake channel interfaces for the request and response sides.
`default_nettype none

interface pas_req_if import pas_pkg::*;;
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [ADDR_W-1:0] addr_hi;
  logic [ADDR_W-1:0] addr_lo;
  logic [LEN_W-1:0]  prefix_len;
  logic [GRP_W-1:0]  group;
  logic [IDX_W-1:0]  index;

  modport source (output valid, mode, addr_hi, addr_lo, prefix_len, group, index,
                  input ready);
  modport sink   (input valid, mode, addr_hi, addr_lo, prefix_len, group, index,
                  output ready);
endinterface

interface pas_rsp_if import pas_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CNT_W-1:0]  entry_count;
  logic [CNT_W-1:0]  removed;
  logic              overflow;
  logic              rd_valid;
  logic [ADDR_W-1:0] rd_addr_hi;
  logic [ADDR_W-1:0] rd_addr_lo;
  logic [LEN_W-1:0]  rd_prefix_len;
  logic [GRP_W-1:0]  rd_group;

  modport source (output valid, entry_count, removed, overflow, rd_valid, rd_addr_hi,
                  rd_addr_lo, rd_prefix_len, rd_group, input ready);
  modport sink   (input valid, entry_count, removed, overflow, rd_valid, rd_addr_hi,
                  rd_addr_lo, rd_prefix_len, rd_group, output ready);
endinterface

`default_nettype wire

// File: hdl/prefix_aggregation_stack.sv
// Top level of the prefix aggregation stack: sequencer, entry memory and merge compare.
//
//   channel | direction | item contents
//   --------+-----------+--------------------------------------------------------
//   req     | in        | mode, addr_hi, addr_lo, prefix_len, group, index
//   rsp     | out       | entry_count, removed, overflow, rd_valid, rd_addr_hi/lo,
//           |           | rd_prefix_len, rd_group
//
// An append passes S_IDLE, then S_CMP, staying in S_CMP for each entry merged
// away; read, clear and the unused mode pass S_IDLE, then S_READ or S_FIN.
// The entry memory has a write port and a registered read port: each compare
// waits for one memory read, and the next lower entry is fetched during the compare.
// Reset (rst, synchronous) empties the stack; the memory itself is not cleared.
// A result sits in the response register until taken; the block stalls in its
// final step while that register is still full.
`default_nettype none

module prefix_aggregation_stack import pas_pkg::*; (
  input  wire        clk,
  input  wire        rst,
  pas_req_if.sink    req,
  pas_rsp_if.source  rsp
);

  // Sequencer states.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]       state;
  logic [CNT_W-1:0] count;      // entries held in the stack
  logic [CNT_W-1:0] n;          // position where the candidate would go
  logic [CNT_W-1:0] removed;    // merges seen during this append
  logic             rd_hit;     // read index was below the count
  entry_t           cand;       // candidate entry that cascades downward

  // Entry memory: one write and one registered read per cycle.
  entry_t           mem [DEPTH];
  entry_t           rd_data;
  logic             mem_we;
  logic [PTR_W-1:0] mem_wa;
  logic             mem_re;
  logic [PTR_W-1:0] mem_ra;

  // Response register.
  logic              out_valid;
  logic [CNT_W-1:0]  out_count;
  logic [CNT_W-1:0]  out_removed;
  logic              out_ovf;
  logic              out_rd_valid;
  logic [ADDR_W-1:0] out_hi;
  logic [ADDR_W-1:0] out_lo;
  logic [LEN_W-1:0]  out_len;
  logic [GRP_W-1:0]  out_grp;

  logic             accept;
  logic             out_free;
  logic             out_load;
  logic             merge;
  logic             same_len;
  logic [LEN_W-1:0] cmp_len;
  logic [PFX_W-1:0] diff;
  logic [LEN_W-1:0] in_len;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign out_free  = !out_valid || rsp.ready;
  assign in_len    = (req.prefix_len > MAX_LEN) ? MAX_LEN : req.prefix_len;

  // The response register is loaded in the final step of every item.
  assign out_load  = out_free && ((state == S_READ) || (state == S_FIN) ||
                                  ((state == S_CMP) && !merge));

  // Merge test: the memory's read data is the entry just below the candidate.
  // Equal lengths compare on one bit fewer and never merge at length zero; a
  // shorter lower entry swallows the candidate if it matches on its length.
  assign same_len = (rd_data.len == cand.len);
  assign cmp_len  = same_len ? (rd_data.len - LEN_W'(1)) : rd_data.len;
  assign diff     = ({rd_data.hi, rd_data.lo} ^ {cand.hi, cand.lo}) & lead_mask(cmp_len);

  always_comb begin
    merge = 1'b0;
    if ((state == S_CMP) && (n != '0) && (rd_data.grp == cand.grp)) begin
      if (same_len) begin
        merge = (rd_data.len != '0) && (diff == '0);
      end else if (rd_data.len < cand.len) begin
        merge = (diff == '0);
      end
    end
  end

  // Memory port control. The next lower entry is fetched while the current one
  // is compared.
  always_comb begin
    mem_re = 1'b0;
    mem_ra = PTR_W'(count - CNT_W'(1));
    mem_we = 1'b0;
    mem_wa = n[PTR_W-1:0];
    case (state)
      S_IDLE: begin
        mem_re = accept;
        if (req.mode == MODE_READ) begin
          mem_ra = PTR_W'(req.index);
        end
      end
      S_CMP: begin
        mem_re = merge;
        mem_ra = PTR_W'(n - CNT_W'(2));
        mem_we = !merge && out_free && (n < CNT_W'(DEPTH));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= cand;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_data <= mem[mem_ra];
    end
  end

  // Sequencer and response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            cand.hi  <= req.addr_hi;
            cand.lo  <= req.addr_lo;
            cand.len <= in_len;
            cand.grp <= req.group & GROUP_MASK;
            n        <= count;
            removed  <= '0;
            rd_hit   <= ({1'b0, req.index} < count);
            case (req.mode)
              MODE_APPEND: state <= S_CMP;
              MODE_READ:   state <= S_READ;
              MODE_CLEAR: begin
                count <= '0;
                state <= S_FIN;
              end
              default:     state <= S_FIN;
            endcase
          end
        end
        S_CMP: begin
          if (merge) begin
            // The lower entry absorbs the candidate and becomes the new candidate.
            cand     <= {rd_data.hi, rd_data.lo, cmp_len, rd_data.grp};
            n        <= n - CNT_W'(1);
            removed  <= removed + CNT_W'(1);
          end else if (out_free) begin
            out_removed  <= removed;
            out_rd_valid <= 1'b0;
            out_hi       <= '0;
            out_lo       <= '0;
            out_len      <= '0;
            out_grp      <= '0;
            if (n < CNT_W'(DEPTH)) begin
              count     <= n + CNT_W'(1);
              out_count <= n + CNT_W'(1);
              out_ovf   <= 1'b0;
            end else begin
              out_count <= count;
              out_ovf   <= (removed == '0);
            end
            state <= S_IDLE;
          end
        end
        S_READ: begin
          if (out_free) begin
            out_count    <= count;
            out_removed  <= '0;
            out_ovf      <= 1'b0;
            out_rd_valid <= rd_hit;
            out_hi       <= rd_hit ? rd_data.hi  : '0;
            out_lo       <= rd_hit ? rd_data.lo  : '0;
            out_len      <= rd_hit ? rd_data.len : '0;
            out_grp      <= rd_hit ? rd_data.grp : '0;
            state        <= S_IDLE;
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_count    <= count;
            out_removed  <= '0;
            out_ovf      <= 1'b0;
            out_rd_valid <= 1'b0;
            out_hi       <= '0;
            out_lo       <= '0;
            out_len      <= '0;
            out_grp      <= '0;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.entry_count   = out_count;
  assign rsp.removed       = out_removed;
  assign rsp.overflow      = out_ovf;
  assign rsp.rd_valid      = out_rd_valid;
  assign rsp.rd_addr_hi    = out_hi;
  assign rsp.rd_addr_lo    = out_lo;
  assign rsp.rd_prefix_len = out_len;
  assign rsp.rd_group      = out_grp;

endmodule

`default_nettype wire

// File: hdl/pas_checker.sv
// Port-level checks for the prefix aggregation stack, bound to the top level.
`default_nettype none

module pas_port_checks import pas_pkg::*; (
  input wire             clk,
  input wire             rst,
  input wire             req_valid,
  input wire             req_ready,
  input wire             rsp_valid,
  input wire             rsp_ready,
  input wire [CNT_W-1:0] entry_count,
  input wire [CNT_W-1:0] removed,
  input wire             overflow,
  input wire             rd_valid
);

  // A pending result is held until it is taken.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped before it was taken");

  // An accept moves the block out of the idle state, so it is busy right after an accept.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken on back-to-back cycles");

  // An overflow only happens when nothing merged.
  a_ovf_no_merge: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(overflow && (removed != '0)))
    else $error("overflow reported together with merges");

  // A valid read implies a non-empty stack, and the count never passes the depth.
  a_count_sane: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (entry_count <= CNT_W'(DEPTH)) && !(rd_valid && (entry_count == '0)))
    else $error("entry count out of range or read from empty stack");

endmodule

bind prefix_aggregation_stack pas_port_checks u_pas_port_checks (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .entry_count (rsp.entry_count),
  .removed     (rsp.removed),
  .overflow    (rsp.overflow),
  .rd_valid    (rsp.rd_valid)
);

`default_nettype wire
